[rtl/rnea_pkg.sv]
package rnea_pkg;

    localparam int MAX_AGENTS_DEF = 64;

    localparam int COUNT_W = 7;
    localparam int AGENT_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd5;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

    // agent status codes held in the status store
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_GRANT = 2'd2;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // one or two grants handed from the sequencer to the result buffer
    typedef struct packed {
        logic               push;
        logic               two;
        logic [AGENT_W-1:0] first;
        logic [AGENT_W-1:0] second;
    } grant_pair_t;

    function automatic logic [COUNT_W-1:0] ring_left(input logic [COUNT_W-1:0] x,
                                                     input logic [COUNT_W-1:0] n);
        return (x == '0) ? n - 7'd1 : x - 7'd1;
    endfunction

    function automatic logic [COUNT_W-1:0] ring_right(input logic [COUNT_W-1:0] x,
                                                      input logic [COUNT_W-1:0] n);
        return (x == n - 7'd1) ? '0 : x + 7'd1;
    endfunction

endpackage

[rtl/rnea_status_ram.sv]
module rnea_status_ram #(
    parameter int DEPTH = rnea_pkg::MAX_AGENTS_DEF,
    parameter int AW    = $clog2(rnea_pkg::MAX_AGENTS_DEF)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

[rtl/rnea_out_buf.sv]
module rnea_out_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rnea_pkg::grant_pair_t         pair,
    output logic                          empty,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rnea_pkg::AGENT_W-1:0]  m_granted_agent,
    output logic                          m_last
);

    logic                         v0_reg, v0_next;
    logic                         v1_reg, v1_next;
    logic [rnea_pkg::AGENT_W-1:0] e0_reg, e0_next;
    logic [rnea_pkg::AGENT_W-1:0] e1_reg, e1_next;
    logic                         l0_reg, l0_next;

    // pushes only arrive when both entries are free; second entry is always last
    always_comb begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        e0_next = e0_reg;
        e1_next = e1_reg;
        l0_next = l0_reg;
        if (pair.push) begin
            v0_next = 1'b1;
            e0_next = pair.first;
            l0_next = !pair.two;
            v1_next = pair.two;
            e1_next = pair.second;
        end else if (v0_reg && m_ready) begin
            v0_next = v1_reg;
            e0_next = e1_reg;
            l0_next = 1'b1;
            v1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
        l0_reg <= l0_next;
    end

    assign empty           = !v0_reg && !v1_reg;
    assign m_valid         = v0_reg;
    assign m_granted_agent = e0_reg;
    assign m_last          = l0_reg;

endmodule

[rtl/rnea_seq.sv]
module rnea_seq #(
    parameter int MAX_AGENTS = rnea_pkg::MAX_AGENTS_DEF,
    parameter int AW         = $clog2(rnea_pkg::MAX_AGENTS_DEF)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rnea_pkg::COUNT_W-1:0]  agent_count,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [rnea_pkg::AGENT_W-1:0]  s_agent,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [1:0]                    ram_wdata,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [1:0]                    ram_rdata,
    input  logic                          out_empty,
    output rnea_pkg::grant_pair_t         pair
);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_CAP  = 6'b001000,
        S_EVAL = 6'b010000,
        S_WR   = 6'b100000
    } seq_state_t;

    localparam int CW = rnea_pkg::COUNT_W;

    seq_state_t       state_reg, state_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             op_reg, op_next;
    logic [CW-1:0]    a_reg, a_next;
    logic [CW-1:0]    slot_reg [4];
    logic [CW-1:0]    slot_next [4];
    logic [1:0]       st_reg [4];
    logic [1:0]       st_next [4];
    logic [CW-1:0]    wa_reg [3];
    logic [CW-1:0]    wa_next [3];
    logic [2:0]       wen_reg, wen_next;
    logic [1:0]       wval_reg, wval_next;

    logic [CW-1:0]    a_in, nl, nr;
    logic [1:0]       s_l, s_ll, s_r0, s_r, s_rr0, s_rr;
    logic             g_l, g_r, g_req, any_grant;

    assign a_in = {1'b0, s_agent};
    assign nl   = rnea_pkg::ring_left(a_in, agent_count);
    assign nr   = rnea_pkg::ring_right(a_in, agent_count);

    // slots: request -> L, R, L, R ; release -> l, left(l), r, right(r)
    // the releasing agent reads as idle; l's grant is seen when testing r
    always_comb begin
        s_l   = (slot_reg[0] == a_reg) ? rnea_pkg::ST_IDLE : st_reg[0];
        s_ll  = (slot_reg[1] == a_reg) ? rnea_pkg::ST_IDLE : st_reg[1];
        g_l   = (s_l == rnea_pkg::ST_WAIT) && (s_ll != rnea_pkg::ST_GRANT);
        s_r0  = (slot_reg[2] == a_reg) ? rnea_pkg::ST_IDLE : st_reg[2];
        s_r   = (slot_reg[2] == slot_reg[0] && g_l) ? rnea_pkg::ST_GRANT : s_r0;
        s_rr0 = (slot_reg[3] == a_reg) ? rnea_pkg::ST_IDLE : st_reg[3];
        s_rr  = (slot_reg[3] == slot_reg[0] && g_l) ? rnea_pkg::ST_GRANT : s_rr0;
        g_r   = (s_r == rnea_pkg::ST_WAIT) && (s_rr != rnea_pkg::ST_GRANT);
        g_req = (st_reg[0] != rnea_pkg::ST_GRANT) && (st_reg[1] != rnea_pkg::ST_GRANT);
        any_grant = (op_reg == rnea_pkg::OP_REQUEST) ? g_req : (g_l || g_r);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        wen_next   = wen_reg;
        wval_next  = wval_reg;
        for (int i = 0; i < 4; i++) begin
            slot_next[i] = slot_reg[i];
            st_next[i]   = st_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            wa_next[i] = wa_reg[i];
        end

        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(wa_reg[cnt_reg]);
        ram_wdata = rnea_pkg::ST_GRANT;
        ram_raddr = AW'(slot_reg[cnt_reg]);
        pair      = '0;

        case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = rnea_pkg::ST_IDLE;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_AGENTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (a_in < agent_count)) begin
                    op_next = s_op;
                    a_next  = a_in;
                    cnt_next = '0;
                    if (s_op == rnea_pkg::OP_REQUEST) begin
                        slot_next[0] = nl;
                        slot_next[1] = nr;
                        slot_next[2] = nl;
                        slot_next[3] = nr;
                    end else begin
                        slot_next[0] = nl;
                        slot_next[1] = rnea_pkg::ring_left(nl, agent_count);
                        slot_next[2] = nr;
                        slot_next[3] = rnea_pkg::ring_right(nr, agent_count);
                    end
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (cnt_reg != 2'd0) begin
                    st_next[cnt_reg - 2'd1] = ram_rdata;
                end
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = S_CAP;
                end
            end
            S_CAP: begin
                st_next[3] = ram_rdata;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (out_empty || !any_grant) begin
                    wa_next[0] = a_reg;
                    wa_next[1] = slot_reg[0];
                    wa_next[2] = slot_reg[2];
                    cnt_next   = '0;
                    state_next = S_WR;
                    pair.push  = any_grant;
                    if (op_reg == rnea_pkg::OP_REQUEST) begin
                        wen_next  = 3'b001;
                        wval_next = g_req ? rnea_pkg::ST_GRANT : rnea_pkg::ST_WAIT;
                        pair.first = a_reg[rnea_pkg::AGENT_W-1:0];
                    end else begin
                        wen_next  = {g_r, g_l, 1'b1};
                        wval_next = rnea_pkg::ST_IDLE;
                        pair.two  = g_l && g_r;
                        pair.first  = g_l ? slot_reg[0][rnea_pkg::AGENT_W-1:0]
                                          : slot_reg[2][rnea_pkg::AGENT_W-1:0];
                        pair.second = slot_reg[2][rnea_pkg::AGENT_W-1:0];
                    end
                end
            end
            S_WR: begin
                ram_we    = wen_reg[cnt_reg];
                ram_wdata = (cnt_reg == 2'd0) ? wval_reg : rnea_pkg::ST_GRANT;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
        op_reg   <= op_next;
        a_reg    <= a_next;
        wen_reg  <= wen_next;
        wval_reg <= wval_next;
        for (int i = 0; i < 4; i++) begin
            slot_reg[i] <= slot_next[i];
            st_reg[i]   <= st_next[i];
        end
        for (int i = 0; i < 3; i++) begin
            wa_reg[i] <= wa_next[i];
        end
    end

endmodule

[rtl/ring_neighbour_exclusion_arbiter.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------
// input     | s_valid / s_ready  | s_op, s_agent
// result    | m_valid / m_ready  | m_granted_agent, m_last
// config    | cfg_we (no wait)   | cfg_wdata (agent count)
//
// A word for an agent on the ring passes, between acceptance and the next
// acceptance, through four status reads on the single read port, a capture,
// an evaluate step and three write-back slots on the single write port.
// Evaluate waits only while the two-entry result buffer still holds grants.
// A word for an agent outside the ring is consumed while the sequencer stays idle.
// After reset the status store is swept to idle, all MAX_AGENTS entries, with
// s_ready low.
module ring_neighbour_exclusion_arbiter #(
    parameter int MAX_AGENTS = rnea_pkg::MAX_AGENTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rnea_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [rnea_pkg::AGENT_W-1:0]  s_agent,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rnea_pkg::AGENT_W-1:0]  m_granted_agent,
    output logic                          m_last
);

    localparam int AW = $clog2(MAX_AGENTS);

    logic [rnea_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [1:0]            ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [1:0]            ram_rdata;
    logic                  out_empty;
    rnea_pkg::grant_pair_t pair;

    // agent count is clamped to the ring limits on write
    always_comb begin
        count_next = count_reg;
        if (cfg_we) begin
            if (cfg_wdata < rnea_pkg::COUNT_MIN) begin
                count_next = rnea_pkg::COUNT_MIN;
            end else if (32'(cfg_wdata) > MAX_AGENTS) begin
                count_next = rnea_pkg::COUNT_W'(MAX_AGENTS);
            end else begin
                count_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= rnea_pkg::COUNT_RESET;
        end else begin
            count_reg <= count_next;
        end
    end

    // status store: one entry per agent, read/modify/write via the sequencer
    rnea_status_ram #(
        .DEPTH (MAX_AGENTS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rnea_seq #(
        .MAX_AGENTS (MAX_AGENTS),
        .AW         (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .agent_count (count_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_agent     (s_agent),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_empty   (out_empty),
        .pair        (pair)
    );

    // result words queue here so the sequencer can move on to the next word
    rnea_out_buf u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pair            (pair),
        .empty           (out_empty),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_agent (m_granted_agent),
        .m_last          (m_last)
    );

endmodule
